// ===== hdl/bswe_pkg.sv =====
// Shared constants, types and state codes for the band-limited saw entry core.
`default_nettype none
package bswe_pkg;

  // Configuration field widths
  localparam int unsigned TL_W  = 13;
  localparam int unsigned NH_W  = 11;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned CFG_ADDR_W = 2;

  // Register indexes on the configuration channel
  localparam logic [CFG_ADDR_W-1:0] REG_TABLE_LENGTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_HARMONICS = 2'd1;

  // Reset values
  localparam logic [TL_W-1:0] TL_RESET = 13'd1024;
  localparam logic [NH_W-1:0] NH_RESET = 11'd64;

  // Defaults for the top level parameters
  localparam int unsigned DEF_MAX_TABLE_LENGTH   = 4096;
  localparam int unsigned DEF_MAX_HARMONIC_COUNT = 1024;
  localparam int unsigned DEF_SAMPLE_WIDTH       = 16;

  // Quarter-sine polynomial coefficients, Q30
  localparam logic [31:0] SIN_A1 = 32'd1686629713;
  localparam logic [31:0] SIN_A3 = 32'd693598668;
  localparam logic [31:0] SIN_A5 = 32'd85569306;
  localparam logic [31:0] SIN_A7 = 32'd4858527;
  // 2/pi in Q24
  localparam logic [31:0] TWO_OVER_PI_Q24 = 32'd10680707;

  // Shared divider geometry
  localparam int unsigned DVS_W   = 13;   // divisor: table length or harmonic number
  localparam int unsigned DVD_W   = 31;   // dividend bits shifted in (sine magnitude)
  localparam int unsigned STEP_W  = 5;
  localparam logic [STEP_W-1:0] PHASE_STEPS = 5'd24;
  localparam logic [STEP_W-1:0] TERM_STEPS  = 5'd31;

  typedef struct packed {
    logic              start;
    logic [DVS_W-1:0]  rem0;
    logic [DVD_W-1:0]  dvd;
    logic [DVS_W-1:0]  dvs;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PDIV,
    S_PWAIT,
    S_MUU,
    S_GU2,
    S_MA7,
    S_GA5,
    S_MT5,
    S_GA3,
    S_MT3,
    S_GA1,
    S_MS,
    S_GS,
    S_TDIV,
    S_TWAIT,
    S_SLO,
    S_SHI,
    S_SCOMB,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== hdl/bswe_mul.sv =====
// Shared 32 x 32 unsigned multiplier with a registered product.
`default_nettype none
module bswe_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [63:0] p_o
);
  logic [63:0] p_q;

  // Register the product for the following cycle
  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

// ===== hdl/bswe_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module bswe_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bswe_pkg::div_req_t    req_i,
  output logic                       busy_o,
  output logic [bswe_pkg::DVD_W-1:0] quot_o
);
  import bswe_pkg::*;

  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVD_W-1:0]  quot_q, quot_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DVS_W:0]    trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial  = {rem_q, dvd_q[DVD_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    rem_d  = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
    quot_d = {quot_q[DVD_W-2:0], fits};
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= req_i.steps;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Operand and quotient registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem0;
      dvd_q  <= req_i.dvd;
      dvs_q  <= req_i.dvs;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= rem_d;
      dvd_q  <= dvd_d;
      quot_q <= quot_d;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

// ===== hdl/bandlimited_saw_wavetable_entry_core.sv =====
// Top level: sequencer, configuration and stream ports of the saw entry core.
// An entry takes one beat in and gives one beat out. Each harmonic runs the
// phase division (24 bit steps), five multiplies on the shared multiplier and
// the 1/k division (31 bit steps), for each of max_harmonics harmonics; an
// out-of-range index, the last index or zero harmonics skip the harmonic loop.
// The input takes no new entry until the result of the last one has gone to
// the output register, which can be held by m_axis_tready. Write the
// registers only while no entry is in flight.
`default_nettype none
module bandlimited_saw_wavetable_entry_core #(
  parameter int unsigned MAX_TABLE_LENGTH   = bswe_pkg::DEF_MAX_TABLE_LENGTH,
  parameter int unsigned MAX_HARMONIC_COUNT = bswe_pkg::DEF_MAX_HARMONIC_COUNT,
  parameter int unsigned SAMPLE_WIDTH       = bswe_pkg::DEF_SAMPLE_WIDTH,
  localparam int unsigned TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bswe_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [bswe_pkg::TL_W-1:0]        cfg_data_i,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [15:0]                      s_axis_tdata,  // [11:0] entry_index
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [TDATA_W-1:0]                    m_axis_tdata,  // sample_value
  output logic                                  m_axis_tuser   // index_error
);
  import bswe_pkg::*;

  localparam int unsigned ACC_W  = 32 + $clog2(MAX_HARMONIC_COUNT + 1);
  localparam int unsigned HI_W   = ACC_W - 32;
  localparam int unsigned PROD_W = ACC_W + 24;
  localparam int unsigned RND_SH = 56 - SAMPLE_WIDTH;

  state_e state_q, state_d;

  logic [TL_W-1:0]  tl_q;
  logic [NH_W-1:0]  nh_q;
  logic [TL_W-1:0]  len_c, len_q;
  logic [NH_W-1:0]  nhc_c, nh_run_q;
  logic [IDX_W-1:0] idx_c, idx_q;
  logic [TL_W-1:0]  r_q;
  logic [NH_W-1:0]  k_q;
  logic [1:0]       quad_q;
  logic [31:0]      u_q, u2_q, t_q, s_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [63:0]      lo_q;
  logic [SAMPLE_WIDTH-1:0] res_q;
  logic             err_q;
  logic             m_valid_q;
  logic [SAMPLE_WIDTH-1:0] m_data_q;
  logic             m_err_q;

  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  div_req_t         div_req;
  logic             div_busy;
  logic [DVD_W-1:0] div_quot;

  logic             s_acc;
  logic [22:0]      xm;
  logic [31:0]      p_hi30;
  logic [TL_W:0]    r_sum;
  logic [ACC_W-1:0] acc_mag;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]  rsum, rmag, lim, sat;
  logic [SAMPLE_WIDTH-1:0] smag;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = state_q == S_IDLE;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign idx_c         = s_axis_tdata[IDX_W-1:0];

  // Clamp registers to the built sizes
  assign len_c = (32'(tl_q) > 32'(MAX_TABLE_LENGTH)) ? TL_W'(MAX_TABLE_LENGTH) : tl_q;
  assign nhc_c = (32'(nh_q) > 32'(MAX_HARMONIC_COUNT)) ? NH_W'(MAX_HARMONIC_COUNT) : nh_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q <= TL_RESET;
      nh_q <= NH_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_TABLE_LENGTH:  tl_q <= cfg_data_i;
        REG_MAX_HARMONICS: nh_q <= cfg_data_i[NH_W-1:0];
        default: ;
      endcase
    end
  end

  bswe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  bswe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  // Datapath helpers
  always_comb begin
    p_hi30  = mul_p[61:30];
    // mirror the position in odd quadrants, taken straight from the new phase
    xm      = div_quot[22] ? 23'(23'd4194304 - {1'b0, div_quot[21:0]})
                           : {1'b0, div_quot[21:0]};
    r_sum   = {1'b0, r_q} + {2'b0, idx_q};
    acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    prod    = PROD_W'(lo_q) + (PROD_W'(mul_p) << 32);
    rsum    = {1'b0, prod} + ((PROD_W + 1)'(1) << (RND_SH - 1));
    rmag    = rsum >> RND_SH;
    lim     = (PROD_W + 1)'(1) << (SAMPLE_WIDTH - 1);
    if (acc_q[ACC_W-1]) begin
      sat = (rmag > lim) ? lim : rmag;
    end else begin
      sat = (rmag > lim - 1'b1) ? lim - 1'b1 : rmag;
    end
    smag = sat[SAMPLE_WIDTH-1:0];
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, multiplier operands and divider requests
  always_comb begin
    state_d       = state_q;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;
    div_req.dvs   = len_q;
    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          if (len_c == '0 || {1'b0, idx_c} >= len_c || {1'b0, idx_c} == len_c - 1'b1
              || nhc_c == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PDIV;
          end
        end
      end
      S_PDIV: begin
        div_req.start = 1'b1;
        div_req.rem0  = r_q;
        div_req.dvd   = '0;
        div_req.dvs   = len_q;
        div_req.steps = PHASE_STEPS;
        state_d       = S_PWAIT;
      end
      S_PWAIT: if (!div_busy) state_d = S_MUU;
      S_MUU: begin
        mul_a = u_q; mul_b = u_q; state_d = S_GU2;
      end
      S_GU2: state_d = S_MA7;
      S_MA7: begin
        mul_a = u2_q; mul_b = SIN_A7; state_d = S_GA5;
      end
      S_GA5: state_d = S_MT5;
      S_MT5: begin
        mul_a = u2_q; mul_b = t_q; state_d = S_GA3;
      end
      S_GA3: state_d = S_MT3;
      S_MT3: begin
        mul_a = u2_q; mul_b = t_q; state_d = S_GA1;
      end
      S_GA1: state_d = S_MS;
      S_MS: begin
        mul_a = u_q; mul_b = t_q; state_d = S_GS;
      end
      S_GS: state_d = S_TDIV;
      S_TDIV: begin
        div_req.start = 1'b1;
        div_req.rem0  = '0;
        div_req.dvd   = s_q[DVD_W-1:0];
        div_req.dvs   = DVS_W'(k_q);
        div_req.steps = TERM_STEPS;
        state_d       = S_TWAIT;
      end
      S_TWAIT: begin
        if (!div_busy) state_d = (k_q == nh_run_q) ? S_SLO : S_PDIV;
      end
      S_SLO: begin
        mul_a = acc_mag[31:0]; mul_b = TWO_OVER_PI_Q24; state_d = S_SHI;
      end
      S_SHI: begin
        mul_a = 32'(acc_mag[32 +: HI_W]); mul_b = TWO_OVER_PI_Q24; state_d = S_SCOMB;
      end
      S_SCOMB: state_d = S_DONE;
      S_DONE: if (!m_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Working registers, advanced per state
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          idx_q    <= idx_c;
          len_q    <= len_c;
          nh_run_q <= nhc_c;
          r_q      <= TL_W'(idx_c);
          k_q      <= NH_W'(1);
          acc_q    <= '0;
          res_q    <= '0;
          err_q    <= len_c == '0 || {1'b0, idx_c} >= len_c;
        end
      end
      S_PWAIT: begin
        quad_q <= div_quot[23:22];
        u_q    <= {1'b0, xm, 8'b0};
      end
      S_GU2: u2_q <= p_hi30;
      S_GA5: t_q  <= SIN_A5 - p_hi30;
      S_GA3: t_q  <= SIN_A3 - p_hi30;
      S_GA1: t_q  <= SIN_A1 - p_hi30;
      S_GS:  s_q  <= p_hi30;
      S_TWAIT: begin
        if (!div_busy) begin
          acc_q <= quad_q[1] ? acc_q - ACC_W'(div_quot) : acc_q + ACC_W'(div_quot);
          k_q   <= k_q + 1'b1;
          r_q   <= (r_sum >= {1'b0, len_q}) ? TL_W'(r_sum - {1'b0, len_q}) : TL_W'(r_sum);
        end
      end
      S_SHI: lo_q <= mul_p;
      S_SCOMB: res_q <= acc_q[ACC_W-1] ? SAMPLE_WIDTH'(-smag) : smag;
      default: ;
    endcase
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= res_q;
      m_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDATA_W'(m_data_q);
  assign m_axis_tuser  = m_err_q;

  // An accepted entry blocks the input until its result is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input taken while an entry is in flight");

  // An out-of-range index always delivers a zero sample
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_data_q == '0)
    else $error("index error with a non-zero sample");

  // The reduced phase stays below the table length
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PDIV |-> r_q < len_q)
    else $error("phase residue out of range");

  // The divider is never restarted while running
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire
